/* hdl/indexed_double_ended_array_defines.svh */
// Assertion macros shared by the block
`ifndef INDEXED_DOUBLE_ENDED_ARRAY_DEFINES_SVH
`define INDEXED_DOUBLE_ENDED_ARRAY_DEFINES_SVH

// same-cycle implication
`define IDEA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idea assertion failed");

// next-cycle implication
`define IDEA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idea assertion failed");

`endif

/* hdl/idea_pkg.sv */
package idea_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int ELEM_WIDTH_DEF = 32;

    // request codes
    localparam logic [2:0] REQ_PUSH    = 3'd0;
    localparam logic [2:0] REQ_POP     = 3'd1;
    localparam logic [2:0] REQ_SHIFT   = 3'd2;
    localparam logic [2:0] REQ_UNSHIFT = 3'd3;
    localparam logic [2:0] REQ_GET     = 3'd4;
    localparam logic [2:0] REQ_SET     = 3'd5;
    localparam logic [2:0] REQ_SPLICE  = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_CAP   = 2'd3;

    // datapath commands
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_LATCH     = 4'd1;
    localparam logic [3:0] CMD_FAIL      = 4'd2;
    localparam logic [3:0] CMD_PUSH      = 4'd3;
    localparam logic [3:0] CMD_POP       = 4'd4;
    localparam logic [3:0] CMD_SHIFT     = 4'd5;
    localparam logic [3:0] CMD_UNSHIFT   = 4'd6;
    localparam logic [3:0] CMD_GROW_INIT = 4'd7;
    localparam logic [3:0] CMD_GROW      = 4'd8;
    localparam logic [3:0] CMD_ACC_WR    = 4'd9;
    localparam logic [3:0] CMD_ACC_RD    = 4'd10;
    localparam logic [3:0] CMD_SPL_INIT  = 4'd11;
    localparam logic [3:0] CMD_MV_RD     = 4'd12;
    localparam logic [3:0] CMD_MV_WR     = 4'd13;
    localparam logic [3:0] CMD_SPL_END   = 4'd14;
    localparam logic [3:0] CMD_CAPTURE   = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] code;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       full;
        logic       empty;
        logic       res_ok;
        logic       pos_ge_cap;
        logic       pos_ge_cnt;
        logic       cnt_zero;
        logic       grow_last;
        logic       spl_moves;
        logic       move_more;
        logic       out_free;
    } stat_t;

endpackage

/* hdl/idea_if.sv */
interface idea_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic signed [8:0] index;
    logic [8:0]        count;
    logic [31:0]       value;

    modport source (output valid, req_type, index, count, value, input ready);
    modport sink   (input valid, req_type, index, count, value, output ready);
endinterface

interface idea_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    logic [1:0]  status;
    logic [8:0]  length;

    modport source (output valid, data, status, length, input ready);
    modport sink   (input valid, data, status, length, output ready);
endinterface

/* hdl/idea_ram.sv */
module idea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/idea_ctrl.sv */
module idea_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  idea_pkg::stat_t stat,
    output idea_pkg::cmd_t  cmd
);
    import idea_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_GROW   = 4'd2;
    localparam logic [3:0] S_ACCESS = 4'd3;
    localparam logic [3:0] S_RDWAIT = 4'd4;
    localparam logic [3:0] S_MV_RD  = 4'd5;
    localparam logic [3:0] S_MV_WR  = 4'd6;
    localparam logic [3:0] S_SPLFIN = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = CMD_NONE;
        cmd.code   = ST_OK;
        cmd.emit   = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = CMD_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                unique case (stat.req)
                    REQ_PUSH, REQ_UNSHIFT:
                    begin
                        if (stat.full)
                        begin
                            cmd.op   = CMD_FAIL;
                            cmd.code = ST_CAP;
                        end
                        else
                        begin
                            cmd.op = (stat.req == REQ_PUSH) ? CMD_PUSH : CMD_UNSHIFT;
                        end
                    end
                    REQ_POP, REQ_SHIFT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.op   = CMD_FAIL;
                            cmd.code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.op     = (stat.req == REQ_POP) ? CMD_POP : CMD_SHIFT;
                            state_next = S_RDWAIT;
                        end
                    end
                    REQ_GET, REQ_SET:
                    begin
                        if (!stat.res_ok)
                        begin
                            cmd.op   = CMD_FAIL;
                            cmd.code = ST_RANGE;
                        end
                        else if (stat.pos_ge_cap)
                        begin
                            cmd.op   = CMD_FAIL;
                            cmd.code = ST_CAP;
                        end
                        else
                        begin
                            cmd.op     = CMD_GROW_INIT;
                            state_next = stat.pos_ge_cnt ? S_GROW : S_ACCESS;
                        end
                    end
                    REQ_SPLICE:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.op = CMD_NONE;
                        end
                        else if (!stat.res_ok || stat.pos_ge_cnt)
                        begin
                            cmd.op   = CMD_FAIL;
                            cmd.code = ST_RANGE;
                        end
                        else
                        begin
                            cmd.op     = CMD_SPL_INIT;
                            state_next = stat.spl_moves ? S_MV_RD : S_SPLFIN;
                        end
                    end
                    default:
                    begin
                        cmd.op = CMD_NONE;
                    end
                endcase
            end
            S_GROW:
            begin
                cmd.op = CMD_GROW;
                if (stat.grow_last)
                begin
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                if (stat.req == REQ_SET)
                begin
                    cmd.op     = CMD_ACC_WR;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = CMD_ACC_RD;
                    state_next = S_RDWAIT;
                end
            end
            S_RDWAIT:
            begin
                cmd.op     = CMD_CAPTURE;
                state_next = S_DONE;
            end
            S_MV_RD:
            begin
                cmd.op     = CMD_MV_RD;
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                cmd.op     = CMD_MV_WR;
                state_next = stat.move_more ? S_MV_RD : S_SPLFIN;
            end
            S_SPLFIN:
            begin
                cmd.op     = CMD_SPL_END;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

/* hdl/idea_datapath.sv */
module idea_datapath #(
    parameter int CAPACITY   = idea_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = idea_pkg::ELEM_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic [2:0]        in_req_type,
    input  logic signed [8:0] in_index,
    input  logic [8:0]        in_count,
    input  logic [31:0]       in_value,
    input  idea_pkg::cmd_t    cmd,
    output idea_pkg::stat_t   stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_data,
    output logic [1:0]        out_status,
    output logic [8:0]        out_length
);
    import idea_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > 9) ? CW : 9;
    localparam int SW = LW + 1;

    logic [2:0]            req_reg;
    logic signed [8:0]     idx_reg;
    logic [8:0]            cin_reg;
    logic [31:0]           val_reg;
    logic [31:0]           fill_reg;
    logic [PW-1:0]         head_reg;
    logic [CW-1:0]         cnt_reg;
    logic [SW-1:0]         pos_reg;
    logic [SW-1:0]         ptr_reg;
    logic [SW-1:0]         rem_reg;
    logic [ELEM_WIDTH-1:0] data_reg;
    logic [1:0]            status_reg;
    logic                  out_valid_reg;
    logic [31:0]           out_data_reg;
    logic [1:0]            out_status_reg;
    logic [8:0]            out_len_reg;

    logic [ELEM_WIDTH-1:0] val_e, fill_e, rdata;
    logic [31:0]           data_w;
    logic [8:0]            mag;
    logic [SW-1:0]         cnt_s, res_pos, avail, rem_calc;
    logic                  ram_we;
    logic [PW-1:0]         ram_waddr, ram_raddr, head_dec;
    logic [ELEM_WIDTH-1:0] ram_wdata;

    generate
        if (ELEM_WIDTH <= 32)
        begin : g_narrow
            assign val_e  = val_reg[ELEM_WIDTH-1:0];
            assign fill_e = fill_reg[ELEM_WIDTH-1:0];
            assign data_w = 32'(data_reg);
        end
        else
        begin : g_wide
            assign val_e  = {{(ELEM_WIDTH - 32){1'b0}}, val_reg};
            assign fill_e = {{(ELEM_WIDTH - 32){1'b0}}, fill_reg};
            assign data_w = data_reg[31:0];
        end
    endgenerate

    function automatic logic [PW-1:0] slot(input logic [PW-1:0] head, input logic [SW-1:0] p);
        logic [SW-1:0] s;
        s = SW'(head) + p;
        if (s >= SW'(CAPACITY))
        begin
            s = s - SW'(CAPACITY);
        end
        return s[PW-1:0];
    endfunction

    // index resolution; negative counts back from the end
    assign mag      = 9'(~idx_reg) + 9'd1;
    assign cnt_s    = SW'(cnt_reg);
    assign res_pos  = idx_reg[8] ? (cnt_s - SW'(mag)) : SW'(idx_reg[7:0]);
    assign avail    = cnt_s - res_pos;
    assign rem_calc = (SW'(cin_reg) < avail) ? SW'(cin_reg) : avail;
    assign head_dec = (head_reg == '0) ? PW'(CAPACITY - 1) : head_reg - PW'(1);

    always_comb
    begin
        stat.req        = req_reg;
        stat.full       = (cnt_reg == CW'(CAPACITY));
        stat.empty      = (cnt_reg == '0);
        stat.res_ok     = !idx_reg[8] || (SW'(mag) <= cnt_s);
        stat.pos_ge_cap = (res_pos >= SW'(CAPACITY));
        stat.pos_ge_cnt = (res_pos >= cnt_s);
        stat.cnt_zero   = (cin_reg == '0);
        stat.grow_last  = (ptr_reg == pos_reg);
        stat.spl_moves  = (res_pos + rem_calc < cnt_s);
        stat.move_more  = (ptr_reg + SW'(1) + rem_reg < cnt_s);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot(head_reg, ptr_reg);
        ram_wdata = fill_e;
        ram_raddr = slot(head_reg, pos_reg);
        unique case (cmd.op)
            CMD_PUSH:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot(head_reg, cnt_s);
                ram_wdata = val_e;
            end
            CMD_UNSHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = head_dec;
                ram_wdata = val_e;
            end
            CMD_POP:     ram_raddr = slot(head_reg, cnt_s - SW'(1));
            CMD_SHIFT:   ram_raddr = head_reg;
            CMD_GROW:    ram_we = 1'b1;
            CMD_ACC_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot(head_reg, pos_reg);
                ram_wdata = val_e;
            end
            CMD_MV_RD:   ram_raddr = slot(head_reg, ptr_reg + rem_reg);
            CMD_MV_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = rdata;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    idea_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            head_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fill_reg <= cfg_wdata;
            end
            unique case (cmd.op)
                CMD_PUSH:    cnt_reg <= cnt_reg + CW'(1);
                CMD_UNSHIFT:
                begin
                    head_reg <= head_dec;
                    cnt_reg  <= cnt_reg + CW'(1);
                end
                CMD_POP:
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        head_reg <= '0;
                    end
                end
                CMD_SHIFT:
                begin
                    cnt_reg  <= cnt_reg - CW'(1);
                    head_reg <= (cnt_reg == CW'(1)) ? '0 : slot(head_reg, SW'(1));
                end
                CMD_GROW:
                begin
                    if (ptr_reg == pos_reg)
                    begin
                        cnt_reg <= CW'(pos_reg + SW'(1));
                    end
                end
                CMD_SPL_END:
                begin
                    cnt_reg <= CW'(cnt_s - rem_reg);
                    if (cnt_s == rem_reg)
                    begin
                        head_reg <= '0;
                    end
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            CMD_LATCH:
            begin
                req_reg    <= in_req_type;
                idx_reg    <= in_index;
                cin_reg    <= in_count;
                val_reg    <= in_value;
                status_reg <= ST_OK;
                data_reg   <= '0;
            end
            CMD_FAIL:      status_reg <= cmd.code;
            CMD_GROW_INIT:
            begin
                pos_reg <= res_pos;
                ptr_reg <= cnt_s;
            end
            CMD_GROW:      ptr_reg <= ptr_reg + SW'(1);
            CMD_SPL_INIT:
            begin
                pos_reg <= res_pos;
                ptr_reg <= res_pos;
                rem_reg <= rem_calc;
            end
            CMD_MV_WR:     ptr_reg <= ptr_reg + SW'(1);
            CMD_CAPTURE:   data_reg <= rdata;
            default:
            begin
                data_reg <= data_reg;
            end
        endcase
        if (cmd.emit)
        begin
            out_data_reg   <= data_w;
            out_status_reg <= status_reg;
            out_len_reg    <= cnt_s[8:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;
    assign out_length = out_len_reg;
endmodule

/* hdl/indexed_double_ended_array.sv */
// Indexed double-ended array: a ring store of CAPACITY words with push/pop at
// the end, shift/unshift at the front, get/set by index and splice.
// req_ch carries one request per beat (req_type, index, count, value);
// rsp_ch returns one beat per request (data, status, length).
// cfg_we/cfg_wdata write the fill word used when get/set grows the array.
// Steps from the accepting edge of a request beat to response valid:
//   push, unshift, failures, no-ops: decode only
//   pop, shift: decode, one registered RAM read; set: decode, one RAM write
//   get: decode, RAM read, capture; get/set first fill slots padded by growth
//   splice: decode, then a read then write of the RAM port per entry moved
// One request is in flight at a time; the next is taken once the response
// is registered, while it still waits on rsp_ch.ready. A stalled receiver
// holds the response and, once a second one is ready, holds the block in
// place.
// Reset empties the array and clears the fill word; store contents are
// undefined until written, but no slot is read before it is written.
`include "indexed_double_ended_array_defines.svh"
module indexed_double_ended_array #(
    parameter int CAPACITY   = idea_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = idea_pkg::ELEM_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    idea_req_if.sink    req_ch,
    idea_rsp_if.source  rsp_ch
);
    import idea_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    idea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req_ch.valid),
        .in_ready (req_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    idea_datapath #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_req_type (req_ch.req_type),
        .in_index    (req_ch.index),
        .in_count    (req_ch.count),
        .in_value    (req_ch.value),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (rsp_ch.valid),
        .out_ready   (rsp_ch.ready),
        .out_data    (rsp_ch.data),
        .out_status  (rsp_ch.status),
        .out_length  (rsp_ch.length)
    );

    `IDEA_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready)
    `IDEA_ASSERT_NOW(a_fail_zero_data, rsp_ch.valid && (rsp_ch.status != ST_OK), rsp_ch.data == '0)
    `IDEA_ASSERT_NOW(a_empty_len, rsp_ch.valid && (rsp_ch.status == ST_EMPTY), rsp_ch.length == '0)
    `IDEA_ASSERT_NOW(a_emit_free, cmd.emit, !rsp_ch.valid || rsp_ch.ready)
endmodule
